@@ hw/rtl/assert_macros.svh @@
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/pwls_pkg.sv @@
// ------------------------------------------------------------------------
// pwls_pkg
// Types and codes shared by the power-weighted light sampler modules.
// ------------------------------------------------------------------------
package pwls_pkg;

	localparam int ACTION_W       = 2;
	localparam int STATUS_W       = 2;
	localparam int PROB_FRAC_BITS = 16;
	localparam int PROB_BITS      = PROB_FRAC_BITS + 1;

	// action codes on the input channel
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd2;

	// status codes on the result channel
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ZERO  = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

	// classified command held in the queue
	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_SAMPLE = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_kind_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic      valid;
		cmd_kind_t kind;
	} q_ctl_t;

	// back end sequencer states
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_ADDR = 6'b000010,
		S_CMP  = 6'b000100,
		S_PWR  = 6'b001000,
		S_DIV  = 6'b010000,
		S_DONE = 6'b100000
	} back_state_t;

endpackage

@@ hw/rtl/pwls_front.sv @@
// ------------------------------------------------------------------------
// pwls_front
// Accepts requests, classifies the action and holds them in a two-entry
// queue for the back end.
// ------------------------------------------------------------------------
module pwls_front #(
	parameter int POWER_BITS = 24,
	parameter int DRAW_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pwls_pkg::ACTION_W-1:0] action,
	input  logic [POWER_BITS-1:0]         light_power,
	input  logic [DRAW_BITS-1:0]          uniform_draw,
	output pwls_pkg::q_ctl_t              q_ctl,
	input  logic                          q_pop,
	output logic [POWER_BITS-1:0]         q_power,
	output logic [DRAW_BITS-1:0]          q_draw
);
	import pwls_pkg::*;

	localparam int Q_DEPTH = 2;
	localparam int PTR_W   = $clog2(Q_DEPTH);
	localparam int CNT_W   = $clog2(Q_DEPTH + 1);

	cmd_kind_t             kind_in;
	cmd_kind_t             kind_mem   [Q_DEPTH];
	logic [POWER_BITS-1:0] power_mem  [Q_DEPTH];
	logic [DRAW_BITS-1:0]  draw_mem   [Q_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;
	logic                  push;

	// classify the action
	always_comb begin
		unique case (action)
			ACT_CLEAR:  kind_in = CMD_CLEAR;
			ACT_APPEND: kind_in = CMD_APPEND;
			ACT_SAMPLE: kind_in = CMD_SAMPLE;
			default:    kind_in = CMD_NOP;
		endcase
	end

	assign in_stall = (count_q == CNT_W'(Q_DEPTH));
	assign push     = in_valid && !in_stall;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			kind_mem[wr_ptr_q]  <= kind_in;
			power_mem[wr_ptr_q] <= light_power;
			draw_mem[wr_ptr_q]  <= uniform_draw;
		end
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (q_pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			case ({push, q_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign q_ctl.valid = (count_q != '0);
	assign q_ctl.kind  = kind_mem[rd_ptr_q];
	assign q_power     = power_mem[rd_ptr_q];
	assign q_draw      = draw_mem[rd_ptr_q];

`include "assert_macros.svh"
	`ASSERT_NEVER(a_q_overfill, count_q > CNT_W'(Q_DEPTH), "queue fill beyond depth")
	`ASSERT_CLK(a_q_pop_empty, q_pop |-> (count_q != '0), "pop from empty queue")
	`ASSERT_CLK(a_q_push_pop, (push && !q_pop) |=> (count_q == $past(count_q) + CNT_W'(1)),
		"queue fill did not follow a push")

endmodule

@@ hw/rtl/pwls_back.sv @@
// ------------------------------------------------------------------------
// pwls_back
// Executes queued commands: keeps the power and cumulative tables, and for
// samples binary-searches the cumulative one and divides out the probability mass.
// ------------------------------------------------------------------------
module pwls_back #(
	parameter int MAX_LIGHTS = 64,
	parameter int POWER_BITS = 24,
	parameter int DRAW_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pwls_pkg::q_ctl_t                     q_ctl,
	output logic                                 q_pop,
	input  logic [POWER_BITS-1:0]                q_power,
	input  logic [DRAW_BITS-1:0]                 q_draw,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [$clog2(MAX_LIGHTS)-1:0]        light_index,
	output logic [pwls_pkg::PROB_BITS-1:0]       power_share,
	output logic [pwls_pkg::STATUS_W-1:0]        status
);
	import pwls_pkg::*;

	localparam int IDX_W  = $clog2(MAX_LIGHTS);
	localparam int CNT_W  = $clog2(MAX_LIGHTS + 1);
	localparam int TOT_W  = POWER_BITS + IDX_W;
	localparam int TGT_W  = TOT_W + DRAW_BITS;
	localparam int STEP_W = $clog2(PROB_BITS);

	back_state_t           st_q;
	logic [CNT_W-1:0]      count_q;
	logic [TOT_W-1:0]      total_q;
	logic [TGT_W-1:0]      target_q;
	logic [CNT_W-1:0]      lo_q;
	logic [CNT_W-1:0]      hi_q;
	logic [CNT_W-1:0]      mid_q;
	logic [IDX_W-1:0]      idx_q;
	logic [TOT_W-1:0]      rem_q;
	logic [PROB_BITS-1:0]  quo_q;
	logic [STEP_W-1:0]     step_q;
	logic [TOT_W-1:0]      cum_rd_q;
	logic [POWER_BITS-1:0] pwr_rd_q;

	logic [TOT_W-1:0]      pwr_mem [MAX_LIGHTS];
	logic [TOT_W-1:0]      cum_mem [MAX_LIGHTS];

	logic                  out_valid_q;
	logic [IDX_W-1:0]      light_index_q;
	logic [PROB_BITS-1:0]  power_share_q;
	logic [STATUS_W-1:0]   status_q;

	logic                  out_free;
	logic                  full;
	logic                  wr_en;
	logic [TOT_W-1:0]      sum_total;
	logic [TGT_W-1:0]      product;
	logic [CNT_W:0]        mid_sum;
	logic [CNT_W-1:0]      mid;
	logic [CNT_W-1:0]      sel;
	logic                  passed;
	logic [TOT_W:0]        trial;
	logic [TOT_W:0]        diff;
	logic                  ge;
	logic                  res_load;
	logic                  search_go;
	logic [IDX_W-1:0]      res_index;
	logic [PROB_BITS-1:0]  res_mass;
	logic [STATUS_W-1:0]   res_status;

	assign out_free  = !out_valid_q || !out_stall;
	assign full      = (count_q == CNT_W'(MAX_LIGHTS));
	assign q_pop     = (st_q == S_IDLE) && q_ctl.valid && out_free;
	assign wr_en     = q_pop && (q_ctl.kind == CMD_APPEND) && !full;
	assign sum_total = total_q + TOT_W'(q_power);
	assign product   = TGT_W'(q_draw) * TGT_W'(total_q);

	// search midpoint and final pick, clamped to the last entry
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CNT_W:1];
	assign sel     = (lo_q >= count_q) ? (count_q - CNT_W'(1)) : lo_q;
	assign passed  = ({cum_rd_q, {DRAW_BITS{1'b0}}} < target_q);

	// restoring divide step, first step takes the power unshifted
	assign trial = (step_q == '0) ? {1'b0, TOT_W'(pwr_rd_q)} : {rem_q, 1'b0};
	assign diff  = trial - {1'b0, total_q};
	assign ge    = (trial >= {1'b0, total_q});

	// result due this cycle: immediate actions at pop, or a finished sample
	always_comb begin
		res_load   = 1'b0;
		search_go  = 1'b0;
		res_index  = '0;
		res_mass   = '0;
		res_status = STATUS_OK;
		if (q_pop) begin
			res_load = 1'b1;
			case (q_ctl.kind)
				CMD_APPEND: begin
					if (full)
						res_status = STATUS_FULL;
				end
				CMD_SAMPLE: begin
					if (count_q == '0) begin
						res_status = STATUS_EMPTY;
					end else if (total_q == '0) begin
						res_status = STATUS_ZERO;
					end else begin
						res_load  = 1'b0;
						search_go = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end else if ((st_q == S_DONE) && out_free) begin
			res_load  = 1'b1;
			res_index = idx_q;
			res_mass  = quo_q;
		end
	end

	// table memories
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pwr_mem[count_q[IDX_W-1:0]] <= TOT_W'(q_power);
			cum_mem[count_q[IDX_W-1:0]] <= sum_total;
		end
		if (st_q == S_ADDR)
			cum_rd_q <= cum_mem[mid[IDX_W-1:0]];
		if (st_q == S_PWR)
			pwr_rd_q <= pwr_mem[sel[IDX_W-1:0]][POWER_BITS-1:0];
	end

	// search and divide datapath
	always_ff @(posedge clk) begin
		if (q_pop)
			target_q <= product;
		if (st_q == S_ADDR)
			mid_q <= mid;
		if (st_q == S_PWR)
			idx_q <= sel[IDX_W-1:0];
		if (st_q == S_DIV) begin
			rem_q <= ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
			quo_q <= {quo_q[PROB_BITS-2:0], ge};
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			light_index_q <= '0;
			power_share_q <= '0;
			status_q      <= STATUS_OK;
		end else if (res_load) begin
			out_valid_q   <= 1'b1;
			light_index_q <= res_index;
			power_share_q <= res_mass;
			status_q      <= res_status;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			count_q <= '0;
			total_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			step_q  <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (q_pop) begin
						case (q_ctl.kind)
							CMD_CLEAR: begin
								count_q <= '0;
								total_q <= '0;
							end
							CMD_APPEND: begin
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
									total_q <= sum_total;
								end
							end
							default: begin
							end
						endcase
						if (search_go) begin
							lo_q <= '0;
							hi_q <= count_q;
							st_q <= S_ADDR;
						end
					end
				end
				S_ADDR: begin
					if (lo_q < hi_q)
						st_q <= S_CMP;
					else
						st_q <= S_PWR;
				end
				S_CMP: begin
					if (passed)
						lo_q <= mid_q + CNT_W'(1);
					else
						hi_q <= mid_q;
					st_q <= S_ADDR;
				end
				S_PWR: begin
					step_q <= '0;
					st_q   <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(PROB_BITS - 1))
						st_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free)
						st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign light_index = light_index_q;
	assign power_share = power_share_q;
	assign status      = status_q;

`include "assert_macros.svh"
	`ASSERT_NEVER(a_count_max, count_q > CNT_W'(MAX_LIGHTS), "light count beyond table size")
	`ASSERT_CLK(a_search_bounds, (st_q == S_ADDR) |-> ((lo_q <= hi_q) && (hi_q <= count_q)),
		"search bounds crossed")
	`ASSERT_CLK(a_mass_range, (st_q == S_DONE) |-> (quo_q <= PROB_BITS'(1 << PROB_FRAC_BITS)),
		"probability mass above one")
	`ASSERT_CLK(a_pop_valid, q_pop |-> q_ctl.valid, "pop without a queued command")

endmodule

@@ hw/rtl/power_weighted_light_sampler.sv @@
// ------------------------------------------------------------------------
// power_weighted_light_sampler
// Power-weighted light sampler: cumulative power table with inverse-CDF
// sampling by binary search and a serial probability-mass divide.
// ------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------
//  input   | in_valid/in_stall  | action, light_power, uniform_draw
//  output  | out_valid/out_stall| light_index, power_share, status
//
// Clear, append and unused actions: with the back end idle and the output
// free, the request is written into the queue, then popped into the result register.
// A sample is popped, then each search step is a table read and a compare,
// followed by a final read, a power read, 17 restoring divide steps and a
// result load. The two-entry queue keeps taking requests, until it holds two,
// while the back end is busy or its result is stalled. Reset (arst_n) empties
// the table and the queue.
// ------------------------------------------------------------------------
module power_weighted_light_sampler #(
	parameter int MAX_LIGHTS = 64,
	parameter int POWER_BITS = 24,
	parameter int DRAW_BITS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [pwls_pkg::ACTION_W-1:0]  action,
	input  logic [POWER_BITS-1:0]          light_power,
	input  logic [DRAW_BITS-1:0]           uniform_draw,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [$clog2(MAX_LIGHTS)-1:0]  light_index,
	output logic [pwls_pkg::PROB_BITS-1:0] power_share,
	output logic [pwls_pkg::STATUS_W-1:0]  status
);
	import pwls_pkg::*;

	q_ctl_t                q_ctl;
	logic                  q_pop;
	logic [POWER_BITS-1:0] q_power;
	logic [DRAW_BITS-1:0]  q_draw;

	// request classification and queue
	pwls_front #(
		.POWER_BITS (POWER_BITS),
		.DRAW_BITS  (DRAW_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.light_power  (light_power),
		.uniform_draw (uniform_draw),
		.q_ctl        (q_ctl),
		.q_pop        (q_pop),
		.q_power      (q_power),
		.q_draw       (q_draw)
	);

	// table, search and divide
	pwls_back #(
		.MAX_LIGHTS (MAX_LIGHTS),
		.POWER_BITS (POWER_BITS),
		.DRAW_BITS  (DRAW_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_ctl       (q_ctl),
		.q_pop       (q_pop),
		.q_power     (q_power),
		.q_draw      (q_draw),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.light_index (light_index),
		.power_share (power_share),
		.status      (status)
	);

endmodule

@@ tb/pwls_result_checker.sv @@
// ------------------------------------------------------------------------
// pwls_result_checker
// Watches both channels of the power-weighted light sampler. It keeps its
// own copy of the power and cumulative tables, works out the result of
// each accepted request and compares results field by field, in order.
// ------------------------------------------------------------------------
module pwls_result_checker #(
	parameter int MAX_LIGHTS = 64,
	parameter int POWER_BITS = 24,
	parameter int DRAW_BITS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [pwls_pkg::ACTION_W-1:0]  action,
	input  logic [POWER_BITS-1:0]          light_power,
	input  logic [DRAW_BITS-1:0]           uniform_draw,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [$clog2(MAX_LIGHTS)-1:0]  light_index,
	input  logic [pwls_pkg::PROB_BITS-1:0] power_share,
	input  logic [pwls_pkg::STATUS_W-1:0]  status,
	output int                             fail_count,
	output int                             pending_results
);
	timeunit 1ns;
	timeprecision 1ps;
	import pwls_pkg::*;

	localparam int IDX_W = $clog2(MAX_LIGHTS);
	localparam int CNT_W = $clog2(MAX_LIGHTS + 1);
	localparam int SUM_W = POWER_BITS + IDX_W;

	typedef struct packed {
		logic [IDX_W-1:0]     index;
		logic [PROB_BITS-1:0] mass;
		logic [STATUS_W-1:0]  status;
	} draw_result_t;

	// shadow of the light tables
	logic [POWER_BITS-1:0] light_powers [MAX_LIGHTS];
	logic [SUM_W-1:0]      running_sums [MAX_LIGHTS];
	logic [CNT_W-1:0]      lights_held;
	logic [SUM_W-1:0]      power_sum;
	draw_result_t          expected_draws [$];

	// one line per mismatch, counted for the verdict
	task automatic report_mismatch(input string msg);
		$display("%0t ns pwls: %s", $time, msg);
		fail_count++;
	endtask

	// apply one request to the shadow tables and return the result it owes
	function automatic draw_result_t apply_request(
		input logic [ACTION_W-1:0]   act,
		input logic [POWER_BITS-1:0] pwr,
		input logic [DRAW_BITS-1:0]  drw
	);
		draw_result_t res;
		logic [63:0]  target;
		logic [63:0]  scaled_sum;
		logic [63:0]  numer;
		int           lo;
		int           hi;
		int           mid;
		res = '0;
		case (act)
		ACT_CLEAR: begin
			lights_held = '0;
			power_sum   = '0;
		end
		ACT_APPEND: begin
			if (lights_held >= MAX_LIGHTS) begin
				res.status = STATUS_FULL;
			end else begin
				power_sum = power_sum + SUM_W'(pwr);
				light_powers[lights_held[IDX_W-1:0]] = pwr;
				running_sums[lights_held[IDX_W-1:0]] = power_sum;
				lights_held++;
			end
		end
		ACT_SAMPLE: begin
			if (lights_held == 0) begin
				res.status = STATUS_EMPTY;
			end else if (power_sum == 0) begin
				res.status = STATUS_ZERO;
			end else begin
				// exact compare: cumulative scaled up against draw times total
				target = 64'(drw);
				target = target * 64'(power_sum);
				lo = 0;
				hi = int'(lights_held);
				while (lo < hi) begin
					mid = (lo + hi) / 2;
					scaled_sum = 64'(running_sums[mid]);
					scaled_sum = scaled_sum << DRAW_BITS;
					if (scaled_sum < target)
						lo = mid + 1;
					else
						hi = mid;
				end
				if (lo >= int'(lights_held))
					lo = int'(lights_held) - 1;
				// truncated quotient in Q1.16
				numer = 64'(light_powers[lo]);
				numer = numer << PROB_FRAC_BITS;
				res.index = IDX_W'(lo);
				res.mass  = PROB_BITS'(numer / 64'(power_sum));
			end
		end
		default: ;
		endcase
		return res;
	endfunction

	// sample both channels at the rising edge: results first, then requests
	always @(posedge clk or negedge arst_n) begin
		draw_result_t want;
		if (!arst_n) begin
			lights_held = '0;
			power_sum   = '0;
			expected_draws.delete();
			pending_results = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_draws.size() == 0) begin
					report_mismatch($sformatf(
						"result with no request waiting: index %0d share %0d status %0d",
						light_index, power_share, status));
				end else begin
					want = expected_draws.pop_front();
					if (light_index !== want.index)
						report_mismatch($sformatf("light_index %0d, expected %0d",
							light_index, want.index));
					if (power_share !== want.mass)
						report_mismatch($sformatf("power_share %0d, expected %0d",
							power_share, want.mass));
					if (status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, want.status));
				end
			end
			if (in_valid && !in_stall)
				expected_draws = {expected_draws,
					apply_request(action, light_power, uniform_draw)};
			pending_results = expected_draws.size();
		end
	end

endmodule

@@ tb/power_weighted_light_sampler_tb.sv @@
// ------------------------------------------------------------------------
// power_weighted_light_sampler_tb
// Drives clear, append and sample requests into the light sampler: a short
// directed run over the edge cases, then random table sessions and noise
// under four idle and stall patterns, with one long result hold-off.
// ------------------------------------------------------------------------
module power_weighted_light_sampler_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pwls_pkg::*;

	localparam int MAX_LIGHTS      = 64;
	localparam int POWER_BITS      = 24;
	localparam int DRAW_BITS       = 16;
	localparam int IDX_W           = $clog2(MAX_LIGHTS);
	localparam int PHASE_ITEMS     = 220;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int QUIET_LIMIT     = 5000;
	localparam int DRAIN_CYCLES    = 60;

	// action code the block ignores
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  in_valid     = 1'b0;
	logic [ACTION_W-1:0]   action       = ACT_CLEAR;
	logic [POWER_BITS-1:0] light_power  = '0;
	logic [DRAW_BITS-1:0]  uniform_draw = '0;
	logic                  out_stall    = 1'b0;
	logic                  in_stall;
	logic                  out_valid;
	logic [IDX_W-1:0]      light_index;
	logic [PROB_BITS-1:0]  power_share;
	logic [STATUS_W-1:0]   status;

	int fail_count;
	int pending_results;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;
	bit hold_req       = 1'b0;

	always #5 clk = ~clk;

	power_weighted_light_sampler #(
		.MAX_LIGHTS (MAX_LIGHTS),
		.POWER_BITS (POWER_BITS),
		.DRAW_BITS  (DRAW_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.light_power  (light_power),
		.uniform_draw (uniform_draw),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.light_index  (light_index),
		.power_share  (power_share),
		.status       (status)
	);

	pwls_result_checker #(
		.MAX_LIGHTS (MAX_LIGHTS),
		.POWER_BITS (POWER_BITS),
		.DRAW_BITS  (DRAW_BITS)
	) i_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.light_power     (light_power),
		.uniform_draw    (uniform_draw),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.light_index     (light_index),
		.power_share     (power_share),
		.status          (status),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	// power for one append; mode picks the flavour of the whole session
	function automatic logic [POWER_BITS-1:0] pick_power(input int mode);
		case (mode)
		0: return POWER_BITS'($urandom);
		1: return POWER_BITS'($urandom_range(15));
		2: return '0;
		default: begin
			case ($urandom_range(3))
			0: return '0;
			1: return '1;
			2: return POWER_BITS'(1);
			default: return POWER_BITS'($urandom);
			endcase
		end
		endcase
	endfunction

	// offer one request from a falling edge; returns at the falling edge
	// after it was taken
	task automatic send_request(
		input logic [ACTION_W-1:0]   act,
		input logic [POWER_BITS-1:0] pwr,
		input logic [DRAW_BITS-1:0]  drw
	);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		light_power  <= pwr;
		uniform_draw <= drw;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// result side: random stall, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_OFF_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("power_weighted_light_sampler_tb: errors");
			$finish;
		end
	end

	// stimulus and verdict
	initial begin
		int                   phase;
		int                   issued;
		int                   n_lights;
		int                   n_draws;
		int                   mode;
		bit                   first_session;
		logic [DRAW_BITS-1:0] drw;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty and zero-total samples, extremes, unused code
		send_request(ACT_SAMPLE, '0, 16'h1234);
		send_request(ACT_UNUSED, '1, '1);
		send_request(ACT_APPEND, '0, '0);
		send_request(ACT_APPEND, '0, '1);
		send_request(ACT_SAMPLE, '1, '1);
		send_request(ACT_CLEAR, '1, '1);
		send_request(ACT_SAMPLE, '0, '0);
		send_request(ACT_APPEND, '1, '0);
		send_request(ACT_APPEND, 24'd1, '0);
		send_request(ACT_APPEND, '0, '0);
		send_request(ACT_APPEND, 24'h800000, '0);
		send_request(ACT_SAMPLE, '0, '0);
		send_request(ACT_SAMPLE, '0, '1);
		send_request(ACT_SAMPLE, '0, 16'h8000);
		send_request(ACT_SAMPLE, '0, 16'd1);
		send_request(ACT_UNUSED, '0, '0);
		send_request(ACT_CLEAR, '0, '0);
		send_request(ACT_APPEND, 24'd5, '0);
		send_request(ACT_SAMPLE, '0, '1);
		send_request(ACT_SAMPLE, '0, '0);

		// random: mostly clear / appends / samples sessions, some noise
		first_session = 1'b1;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct  = 56;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 56;
				hold_req       = 1'b1;
			end
			default: begin
				send_idle_pct  = 23;
				recv_stall_pct = 23;
			end
			endcase
			issued = 0;
			while (issued < PHASE_ITEMS) begin
				if ($urandom_range(99) < 85) begin
					// first session overfills the table
					if (first_session)
						n_lights = MAX_LIGHTS + 2;
					else if ($urandom_range(9) == 0)
						n_lights = $urandom_range(MAX_LIGHTS + 6, 40);
					else
						n_lights = $urandom_range(8, 1);
					first_session = 1'b0;
					mode    = $urandom_range(3);
					n_draws = $urandom_range(6, 1);
					send_request(ACT_CLEAR, POWER_BITS'($urandom), DRAW_BITS'($urandom));
					for (int i = 0; i < n_lights; i++)
						send_request(ACT_APPEND, pick_power(mode), DRAW_BITS'($urandom));
					for (int i = 0; i < n_draws; i++) begin
						case ($urandom_range(5))
						0: drw = '0;
						1: drw = '1;
						default: drw = DRAW_BITS'($urandom);
						endcase
						send_request(ACT_SAMPLE, POWER_BITS'($urandom), drw);
					end
					issued += 1 + n_lights + n_draws;
				end else begin
					send_request(ACTION_W'($urandom_range(3)), POWER_BITS'($urandom),
						DRAW_BITS'($urandom));
					issued++;
				end
			end
			// sender pauses until the block has drained
			in_valid <= 1'b0;
			wait (pending_results == 0);
			@(negedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("power_weighted_light_sampler_tb: clean");
		else
			$display("power_weighted_light_sampler_tb: errors");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/pwls_pkg.sv
hw/rtl/pwls_front.sv
hw/rtl/pwls_back.sv
hw/rtl/power_weighted_light_sampler.sv
tb/pwls_result_checker.sv
tb/power_weighted_light_sampler_tb.sv
